// ----- sv/vbmm_pkg.sv -----
// vbmm_pkg: shared types and constants for the volume brick min/max unit.
// No dependencies; imported by every module of the block.

package vbmm_pkg;

  localparam int BRICK_DEF   = 8;
  localparam int MAX_DIM_DEF = 256;

  localparam int DENS_W     = 16;
  localparam int IDX_W      = 15;
  localparam int CFG_SIZE_W = 9;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SIZE_RST   = 64;
  localparam int THR_RST    = 4;

  // result queue, depth a power of two
  localparam int OUTQ_DEPTH = 4;
  localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2,
    CFG_THRESH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic first;
    logic emit;
    logic part;
    logic done;
  } vox_flags_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DENS_W-1:0] mn;
    logic signed [DENS_W-1:0] mx;
    logic                     active;
    logic                     done;
  } brick_res_t;

endpackage

// ----- sv/volume_brick_min_max_unit.sv -----
// volume_brick_min_max_unit: per-brick min/max summary of a raster voxel stream.
// Depends on vbmm_pkg, vbmm_accum (slab memory pipeline) and vbmm_outq (result queue).
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_density
//  out_    | output    | out_valid / out_stall | brick_index, brick_min/max, active, volume_done
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One voxel per cycle while in_stall is low. A result shows on out_valid after the beat
// that closes its brick: position counters, then slab memory read, then merge and write,
// then the result queue. Reset clears position and queue and loads the default sizes;
// the slab memory is not cleared, each entry is set by the first voxel of its brick.
// in_stall rises when queued plus in-flight results reach the four-entry result queue.

module volume_brick_min_max_unit import vbmm_pkg::*; #(
  parameter int BRICK   = BRICK_DEF,
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DENS_W-1:0] in_density,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_brick_index,
  output logic signed [DENS_W-1:0] out_brick_min,
  output logic signed [DENS_W-1:0] out_brick_max,
  output logic                     out_active,
  output logic                     out_volume_done
);

  localparam int SW      = $clog2(MAX_DIM + 1);
  localparam int PW      = $clog2(MAX_DIM);
  localparam int LW      = $clog2(BRICK);
  localparam int BPA     = (MAX_DIM + BRICK - 1) / BRICK;
  localparam int NW      = $clog2(BPA + 1);
  localparam int BXW     = (BPA > 1) ? $clog2(BPA) : 1;
  localparam int SLAB    = BPA * BPA;
  localparam int SLW     = (SLAB > 1) ? $clog2(SLAB) : 1;
  localparam int NXW     = $clog2(SLAB + 1);
  localparam int XW      = (SW > CFG_SIZE_W) ? SW : CFG_SIZE_W;
  localparam int NN      = $clog2(MAX_DIM + BRICK);
  localparam int RSH     = NN + LW;
  localparam int PRW     = NN + RSH;
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(BRICK) - 64'd1) / 64'(BRICK);
  localparam int RST_EFF = (MAX_DIM < SIZE_RST) ? MAX_DIM : SIZE_RST;
  localparam int RST_NB  = (RST_EFF + BRICK - 1) / BRICK;
  localparam int QCW     = $clog2(OUTQ_DEPTH + 3);

  // configuration, held as effective size and brick count
  logic [SW-1:0]            sx_r, sy_r, sz_r;
  logic [NW-1:0]            nbx_r, nby_r;
  logic [NXW-1:0]           nbxy_r;
  logic signed [DENS_W-1:0] thr_r;

  logic [XW-1:0]  size_ext;
  logic [SW-1:0]  eff_w;
  logic [NN-1:0]  nb_num;
  logic [PRW-1:0] nb_prod;
  logic [NW-1:0]  nb_w;

  always_comb begin
    size_ext = XW'(cfg_wdata[CFG_SIZE_W-1:0]);
    if (size_ext == '0) begin
      eff_w = SW'(1);
    end else if (size_ext > XW'(MAX_DIM)) begin
      eff_w = SW'(MAX_DIM);
    end else begin
      eff_w = SW'(size_ext);
    end
    nb_num  = NN'(eff_w) + NN'(BRICK - 1);
    nb_prod = PRW'(nb_num) * PRW'(RECIP);
    nb_w    = NW'(nb_prod >> RSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r   <= SW'(RST_EFF);
      sy_r   <= SW'(RST_EFF);
      sz_r   <= SW'(RST_EFF);
      nbx_r  <= NW'(RST_NB);
      nby_r  <= NW'(RST_NB);
      nbxy_r <= NXW'(RST_NB * RST_NB);
      thr_r  <= DENS_W'(THR_RST);
    end else begin
      nbxy_r <= NXW'(nbx_r) * NXW'(nby_r);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SIZE_X: begin
            sx_r  <= eff_w;
            nbx_r <= nb_w;
          end
          CFG_SIZE_Y: begin
            sy_r  <= eff_w;
            nby_r <= nb_w;
          end
          CFG_SIZE_Z: sz_r  <= eff_w;
          CFG_THRESH: thr_r <= cfg_wdata[DENS_W-1:0];
        endcase
      end
    end
  end

  // raster position: voxel, in-brick offset and brick coordinate per axis
  logic [PW-1:0]  pos_r [3];
  logic [LW-1:0]  loc_r [3];
  logic [BXW-1:0] blk_r [3];
  logic [PW-1:0]  pos_nxt [3];
  logic [LW-1:0]  loc_nxt [3];
  logic [BXW-1:0] blk_nxt [3];
  logic [PW-1:0]  cpos [3];
  logic [LW-1:0]  cloc [3];
  logic [BXW-1:0] cblk [3];
  logic [SW-1:0]  eff_a [3];
  logic [2:0]     ends, lasts, parts, step;
  vox_flags_t     flg_now;
  logic           in_acc;

  assign eff_a[0] = sx_r;
  assign eff_a[1] = sy_r;
  assign eff_a[2] = sz_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (SW'(pos_r[a]) >= eff_a[a]) begin
        cpos[a] = '0;
        cloc[a] = '0;
        cblk[a] = '0;
      end else begin
        cpos[a] = pos_r[a];
        cloc[a] = loc_r[a];
        cblk[a] = blk_r[a];
      end
      ends[a]  = (SW'(cpos[a]) + SW'(1)) >= eff_a[a];
      lasts[a] = ends[a] || (cloc[a] == LW'(BRICK - 1));
      parts[a] = ((NN'(cblk[a]) + NN'(1)) * NN'(BRICK)) > NN'(eff_a[a]);
    end
    step[0] = 1'b1;
    step[1] = ends[0];
    step[2] = ends[0] && ends[1];
    for (int a = 0; a < 3; a++) begin
      pos_nxt[a] = cpos[a];
      loc_nxt[a] = cloc[a];
      blk_nxt[a] = cblk[a];
      if (step[a]) begin
        if (ends[a]) begin
          pos_nxt[a] = '0;
          loc_nxt[a] = '0;
          blk_nxt[a] = '0;
        end else begin
          pos_nxt[a] = cpos[a] + PW'(1);
          if (cloc[a] == LW'(BRICK - 1)) begin
            loc_nxt[a] = '0;
            blk_nxt[a] = cblk[a] + BXW'(1);
          end else begin
            loc_nxt[a] = cloc[a] + LW'(1);
          end
        end
      end
    end
    flg_now.first = (cloc[0] == '0) && (cloc[1] == '0) && (cloc[2] == '0);
    flg_now.emit  = &lasts;
    flg_now.part  = |parts;
    flg_now.done  = &ends;
  end

  logic [OQ_CW-1:0] q_cnt;
  logic             s2_pend;
  logic [QCW-1:0]   credit;

  logic                     s1_v_r;
  vox_flags_t               s1_flg_r;
  logic signed [DENS_W-1:0] s1_d_r;
  logic [BXW-1:0]           s1_bx_r, s1_by_r, s1_bz_r;

  assign credit   = QCW'(q_cnt) + QCW'(s1_v_r && s1_flg_r.emit) + QCW'(s2_pend);
  assign in_stall = credit >= QCW'(OUTQ_DEPTH);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        pos_r[a] <= '0;
        loc_r[a] <= '0;
        blk_r[a] <= '0;
      end
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      if (in_acc) begin
        pos_r <= pos_nxt;
        loc_r <= loc_nxt;
        blk_r <= blk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_flg_r <= flg_now;
    s1_d_r   <= in_density;
    s1_bx_r  <= cblk[0];
    s1_by_r  <= cblk[1];
    s1_bz_r  <= cblk[2];
  end

  logic       push;
  brick_res_t push_res;
  brick_res_t q_res;

  vbmm_accum #(
    .BXW  (BXW),
    .NW   (NW),
    .NXW  (NXW),
    .SLW  (SLW),
    .SLAB (SLAB)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_v     (s1_v_r),
    .s1_flg   (s1_flg_r),
    .s1_d     (s1_d_r),
    .s1_bx    (s1_bx_r),
    .s1_by    (s1_by_r),
    .s1_bz    (s1_bz_r),
    .nbx      (nbx_r),
    .nbxy     (nbxy_r),
    .thr      (thr_r),
    .s2_pend  (s2_pend),
    .push     (push),
    .push_res (push_res)
  );

  vbmm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (push_res),
    .pop_stall (out_stall),
    .q_valid   (out_valid),
    .q_res     (q_res),
    .q_cnt     (q_cnt)
  );

  assign out_brick_index = q_res.idx;
  assign out_brick_min   = q_res.mn;
  assign out_brick_max   = q_res.mx;
  assign out_active      = q_res.active;
  assign out_volume_done = q_res.done;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit <= QCW'(OUTQ_DEPTH))
    else $error("more results in flight than queue entries");

  a_wrap_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && flg_now.done) |=> (pos_r[0] == '0) && (pos_r[1] == '0) && (pos_r[2] == '0))
    else $error("position did not wrap after final voxel");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_flg_r.done) |-> s1_flg_r.emit)
    else $error("final voxel of volume did not close a brick");

endmodule

// ----- sv/vbmm_accum.sv -----
// vbmm_accum: slab accumulator memory with read-modify-write pipeline.
// Depends on vbmm_pkg; slot and index arithmetic, forwarding, result forming.

module vbmm_accum import vbmm_pkg::*; #(
  parameter int BXW  = 5,
  parameter int NW   = 6,
  parameter int NXW  = 11,
  parameter int SLW  = 10,
  parameter int SLAB = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s1_v,
  input  vox_flags_t               s1_flg,
  input  logic signed [DENS_W-1:0] s1_d,
  input  logic [BXW-1:0]           s1_bx,
  input  logic [BXW-1:0]           s1_by,
  input  logic [BXW-1:0]           s1_bz,
  input  logic [NW-1:0]            nbx,
  input  logic [NXW-1:0]           nbxy,
  input  logic signed [DENS_W-1:0] thr,
  output logic                     s2_pend,
  output logic                     push,
  output brick_res_t               push_res
);

  localparam int RW = BXW + NW;
  localparam int ZW = BXW + NXW;

  logic [2*DENS_W-1:0] mem [SLAB];
  logic [2*DENS_W-1:0] rd_q;
  logic [2*DENS_W-1:0] acc_r;
  logic [2*DENS_W-1:0] wr_data;

  logic [RW-1:0]  row;
  logic [SLW-1:0] slot;
  logic [ZW-1:0]  slab_prod;

  logic                     s2_v_r;
  vox_flags_t               s2_flg_r;
  logic signed [DENS_W-1:0] s2_d_r;
  logic [SLW-1:0]           s2_slot_r;
  logic [IDX_W-1:0]         s2_slab_r;
  logic                     fwd_r;

  logic signed [DENS_W-1:0] old_mn, old_mx, new_mn, new_mx, res_mn, res_mx;

  assign row       = RW'(s1_by) * RW'(nbx);
  assign slot      = SLW'(row + RW'(s1_bx));
  assign slab_prod = ZW'(s1_bz) * ZW'(nbxy);

  always_ff @(posedge clk) begin
    if (s1_v) begin
      rd_q <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      mem[s2_slot_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      s2_v_r <= s1_v;
      fwd_r  <= s2_v_r && (s2_slot_r == slot);
    end
  end

  always_ff @(posedge clk) begin
    s2_flg_r  <= s1_flg;
    s2_d_r    <= s1_d;
    s2_slot_r <= slot;
    s2_slab_r <= IDX_W'(slab_prod);
    if (s2_v_r) begin
      acc_r <= wr_data;
    end
  end

  // entry just written by the previous beat bypasses the memory
  always_comb begin
    old_mn = fwd_r ? acc_r[2*DENS_W-1:DENS_W] : rd_q[2*DENS_W-1:DENS_W];
    old_mx = fwd_r ? acc_r[DENS_W-1:0]        : rd_q[DENS_W-1:0];
    if (s2_flg_r.first) begin
      new_mn = s2_d_r;
      new_mx = s2_d_r;
    end else begin
      new_mn = (s2_d_r < old_mn) ? s2_d_r : old_mn;
      new_mx = (s2_d_r > old_mx) ? s2_d_r : old_mx;
    end
    wr_data = {new_mn, new_mx};
    res_mn  = new_mn;
    res_mx  = new_mx;
    if (s2_flg_r.part) begin
      if (new_mn > 0) res_mn = '0;
      if (new_mx < 0) res_mx = '0;
    end
  end

  assign s2_pend         = s2_v_r && s2_flg_r.emit;
  assign push            = s2_pend;
  assign push_res.idx    = s2_slab_r + IDX_W'(s2_slot_r);
  assign push_res.mn     = res_mn;
  assign push_res.mx     = res_mx;
  assign push_res.active = res_mx > thr;
  assign push_res.done   = s2_flg_r.done;

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(s2_v_r))
    else $error("forward taken without a preceding write");

  a_push_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(s1_v) && $past(s1_flg.emit))
    else $error("result pushed without an emitting beat");

endmodule

// ----- sv/vbmm_outq.sv -----
// vbmm_outq: small result queue decoupling the pipeline from out_stall.
// Depends on vbmm_pkg for the result type and queue depth.

module vbmm_outq import vbmm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  brick_res_t       push_res,
  input  logic             pop_stall,
  output logic             q_valid,
  output brick_res_t       q_res,
  output logic [OQ_CW-1:0] q_cnt
);

  brick_res_t       q [OUTQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;
  logic             pop;

  assign q_valid = cnt_r != '0;
  assign pop     = q_valid && !pop_stall;
  assign q_res   = q[rd_ptr_r];
  assign q_cnt   = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      if (push && !pop) begin
        cnt_r <= cnt_r + OQ_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - OQ_CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (cnt_r == OQ_CW'(OUTQ_DEPTH))))
    else $error("result queue overflow");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + OQ_CW'(1))
    else $error("queue count lost a push");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - OQ_CW'(1))
    else $error("queue count lost a pop");

endmodule
